// File: rtl/lif_pkg.sv
package lif_pkg;

  localparam int CFG_W = 31;
  localparam int ROUGH_W = 16;
  localparam int INDEX_W = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [63:0] SAT31_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // Face kinds; the unused code is handled as an active face
  localparam logic [1:0] FACE_INACTIVE   = 2'd0;
  localparam logic [1:0] FACE_CONTINUOUS = 2'd1;
  localparam logic [1:0] FACE_STEP       = 2'd2;
  localparam logic [1:0] FACE_UNUSED     = 2'd3;

  typedef enum logic [INDEX_W-1:0] {
    REG_GRAVITY   = 3'd0,
    REG_TIME_STEP = 3'd1,
    REG_CELL_SIZE = 3'd2,
    REG_MANNING_N = 3'd3,
    REG_DEPTH_THR = 3'd4,
    REG_MAX_DEPTH = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0]   gravity;
    logic [CFG_W-1:0]   time_step;
    logic [CFG_W-1:0]   cell_size;
    logic [ROUGH_W-1:0] manning_n;
    logic [CFG_W-1:0]   depth_threshold;
    logic [CFG_W-1:0]   max_flow_depth;
  } cfg_t;

  // Classified face as handed from the front end to the back end
  typedef struct packed {
    logic               pass;
    logic               dry;
    logic [31:0]        q_old;
    logic [30:0]        qv;
    logic [30:0]        h;
    logic signed [33:0] ds;
  } face_t;

  function automatic logic [30:0] sat31(input logic [63:0] v);
    logic [30:0] r;
    r = (v > SAT31_MAX) ? 31'h7FFF_FFFF : v[30:0];
    return r;
  endfunction

endpackage

// File: rtl/lif_front.sv
module lif_front (
  input  logic            clk,
  input  logic            rst,
  input  lif_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      face_kind,
  input  logic [31:0]     q_old,
  input  logic [30:0]     friction_discharge,
  input  logic [30:0]     depth_left,
  input  logic [31:0]     bed_left,
  input  logic [30:0]     depth_right,
  input  logic [31:0]     bed_right,
  output logic            face_valid,
  input  logic            face_ready,
  output lif_pkg::face_t  face
);
  import lif_pkg::*;

  logic               adv;
  logic               f1_valid;
  logic [1:0]         f1_kind;
  logic [31:0]        f1_q_old;
  logic [30:0]        f1_qv;
  logic signed [32:0] f1_sl;
  logic signed [32:0] f1_sr;
  logic signed [31:0] f1_zl;
  logic signed [31:0] f1_zr;

  logic signed [32:0] surf_max;
  logic signed [31:0] bed_max;
  logic signed [33:0] hs;
  logic [30:0]        h_clamp;
  face_t              face_next;

  assign adv = !face_valid || face_ready;
  assign in_ready = adv;

  // Capture the face and form both water surfaces
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
    end
    if (adv) begin
      f1_kind  <= face_kind;
      f1_q_old <= q_old;
      f1_qv    <= friction_discharge;
      f1_sl    <= $signed({bed_left[31], bed_left}) + $signed({2'b00, depth_left});
      f1_sr    <= $signed({bed_right[31], bed_right}) + $signed({2'b00, depth_right});
      f1_zl    <= $signed(bed_left);
      f1_zr    <= $signed(bed_right);
    end
  end

  // Flow depth, clamp and dry test
  always_comb begin
    surf_max = (f1_sl > f1_sr) ? f1_sl : f1_sr;
    bed_max  = (f1_zl > f1_zr) ? f1_zl : f1_zr;
    hs = $signed({surf_max[32], surf_max}) - $signed({{2{bed_max[31]}}, bed_max});
    if (hs[33]) begin
      h_clamp = '0;
    end else if (hs[32:0] > {2'b00, cfg.max_flow_depth}) begin
      h_clamp = cfg.max_flow_depth;
    end else begin
      h_clamp = hs[30:0];
    end
    face_next.pass  = (f1_kind == FACE_INACTIVE);
    face_next.dry   = (h_clamp < cfg.depth_threshold) || (h_clamp == '0);
    face_next.q_old = f1_q_old;
    face_next.qv    = f1_qv;
    face_next.h     = h_clamp;
    face_next.ds    = $signed({f1_sr[32], f1_sr}) - $signed({f1_sl[32], f1_sl});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
    end else if (adv) begin
      face_valid <= f1_valid;
    end
    if (adv) begin
      face <= face_next;
    end
  end

endmodule

// File: rtl/lif_queue.sv
module lif_queue #(
  parameter int DEPTH = lif_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  lif_pkg::face_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lif_pkg::face_t pop_data
);
  import lif_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  face_t         entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entry[rd_ptr];

  // Store incoming transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lif_cbrt.sv
module lif_cbrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   x,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [20:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int STEPS = 22;

  logic          vld  [STEPS+1];
  logic [63:0]   rem  [STEPS+1];
  logic [21:0]   y    [STEPS+1];
  logic [SW-1:0] side [STEPS+1];

  // Load the operand
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= x;
      y[0]    <= '0;
      side[0] <= side_in;
    end
  end

  // One root bit per stage, three radicand bits at a time
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int S = 63 - 3 * k;
    logic [22:0] y2;
    logic [22:0] y2p;
    logic [45:0] pr;
    logic [47:0] b;
    logic        take;

    always_comb begin
      y2   = {y[k][21:0], 1'b0};
      y2p  = y2 + 23'd1;
      pr   = 46'(y2) * 46'(y2p);
      b    = {2'b00, pr} + {1'b0, pr, 1'b0} + 48'd1;
      take = ((rem[k] >> S) >= {16'b0, b});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= take ? rem[k] - ({16'b0, b} << S) : rem[k];
        y[k+1]    <= take ? 22'(y2) + 22'd1 : 22'(y2);
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = y[STEPS][20:0];
  assign side_out  = side[STEPS];

endmodule

// File: rtl/lif_div.sv
module lif_div #(
  parameter int DW = 48,
  parameter int VW = 32,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  localparam int CW = (DW > VW + QW) ? DW : VW + QW;

  logic          vld  [QW+1];
  logic          ovf  [QW+1];
  logic [DW-1:0] rem  [QW+1];
  logic [VW-1:0] dv   [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [SW-1:0] side [QW+1];

  // Load operands and flag a quotient that does not fit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      ovf[0]  <= (CW'(dividend) >= (CW'(divisor) << QW));
      rem[0]  <= dividend;
      dv[0]   <= divisor;
      q[0]    <= '0;
      side[0] <= side_in;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic [CW-1:0] trial;
    logic          take;

    always_comb begin
      trial = CW'(dv[k-1]) << B;
      take  = (CW'(rem[k-1]) >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        ovf[k]  <= ovf[k-1];
        rem[k]  <= take ? DW'(CW'(rem[k-1]) - trial) : rem[k-1];
        dv[k]   <= dv[k-1];
        q[k]    <= q[k-1] | (take ? (QW'(1) << B) : '0);
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = ovf[QW] ? '1 : q[QW];
  assign side_out  = side[QW];

endmodule

// File: rtl/lif_back.sv
module lif_back (
  input  logic           clk,
  input  logic           rst,
  input  lif_pkg::cfg_t  cfg,
  input  logic           face_valid,
  output logic           face_ready,
  input  lif_pkg::face_t face,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    q_new,
  output logic           went_dry,
  output logic           passed_through
);
  import lif_pkg::*;

  typedef struct packed {
    face_t       f;
    logic [20:0] c;
    logic [30:0] drive;
    logic [30:0] f2;
    logic        neg_ds;
  } s1_t;

  typedef struct packed {
    logic               pass;
    logic               dry;
    logic [31:0]        q_old;
    logic signed [33:0] numer;
    logic [30:0]        h;
    logic [20:0]        c;
  } s2_t;

  typedef struct packed {
    logic        pass;
    logic        dry;
    logic [31:0] q_old;
    logic        neg;
  } s4_t;

  logic adv;

  // Whole back end moves together while the output register can take data
  assign adv = !out_valid || out_ready;
  assign face_ready = adv;

  // Cube root of the flow depth
  logic        cb_v;
  logic [20:0] cb_root;
  face_t       cb_face;

  lif_cbrt #(.SW($bits(face_t))) u_cbrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(face_valid),
    .x({1'b0, face.h, 32'b0}), .side_in(face),
    .out_valid(cb_v), .root(cb_root), .side_out(cb_face)
  );

  // g*dt and n^2
  logic        m1_v;
  face_t       m1_f;
  logic [20:0] m1_c;
  logic [30:0] m1_gdt;
  logic [15:0] m1_n2;
  logic [31:0] n_sq;

  assign n_sq = 32'(cfg.manning_n) * 32'(cfg.manning_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= cb_v;
    end
    if (adv) begin
      m1_f   <= cb_face;
      m1_c   <= cb_root;
      m1_gdt <= sat31((64'(cfg.gravity) * 64'(cfg.time_step)) >> 16);
      m1_n2  <= n_sq[31:16];
    end
  end

  // Drive and first friction factor
  logic        m2_v;
  face_t       m2_f;
  logic [20:0] m2_c;
  logic [30:0] m2_drive;
  logic [30:0] m2_f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (adv) begin
      m2_v <= m1_v;
    end
    if (adv) begin
      m2_f     <= m1_f;
      m2_c     <= m1_c;
      m2_drive <= sat31((64'(m1_gdt) * 64'(m1_f.h)) >> 16);
      m2_f1    <= sat31((64'(m1_gdt) * 64'(m1_n2)) >> 16);
    end
  end

  // Friction times discharge, slope magnitude
  logic        m3_v;
  s1_t         m3_s;
  logic [32:0] m3_dsmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (adv) begin
      m3_v <= m2_v;
    end
    if (adv) begin
      m3_s.f      <= m2_f;
      m3_s.c      <= m2_c;
      m3_s.drive  <= m2_drive;
      m3_s.f2     <= sat31((64'(m2_f1) * 64'(m2_f.qv)) >> 16);
      m3_s.neg_ds <= m2_f.ds[33];
      m3_dsmag    <= m2_f.ds[33] ? 33'(-m2_f.ds) : m2_f.ds[32:0];
    end
  end

  // Slope = |ds| / cell_size
  logic [30:0] cs_eff;
  logic        sd_v;
  logic [30:0] sd_q;
  s1_t         sd_s;

  assign cs_eff = (cfg.cell_size == '0) ? 31'd1 : cfg.cell_size;

  lif_div #(.DW(49), .VW(31), .QW(31), .SW($bits(s1_t))) u_div_slope (
    .clk(clk), .rst(rst), .en(adv), .in_valid(m3_v),
    .dividend({m3_dsmag, 16'b0}), .divisor(cs_eff), .side_in(m3_s),
    .out_valid(sd_v), .quotient(sd_q), .side_out(sd_s)
  );

  // Slope term
  logic        m4_v;
  s1_t         m4_s;
  logic [30:0] m4_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_v <= 1'b0;
    end else if (adv) begin
      m4_v <= sd_v;
    end
    if (adv) begin
      m4_s    <= sd_s;
      m4_term <= sat31((64'(sd_s.drive) * 64'(sd_q)) >> 16);
    end
  end

  // Numerator
  logic        m5_v;
  s2_t         m5_s;
  logic [30:0] m5_f2;
  logic signed [33:0] q_ext;
  logic signed [33:0] t_ext;

  assign q_ext = $signed({{2{m4_s.f.q_old[31]}}, m4_s.f.q_old});
  assign t_ext = $signed({3'b000, m4_term});

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_v <= 1'b0;
    end else if (adv) begin
      m5_v <= m4_v;
    end
    if (adv) begin
      m5_s.pass  <= m4_s.f.pass;
      m5_s.dry   <= m4_s.f.dry;
      m5_s.q_old <= m4_s.f.q_old;
      m5_s.numer <= m4_s.neg_ds ? q_ext + t_ext : q_ext - t_ext;
      m5_s.h     <= m4_s.f.h;
      m5_s.c     <= m4_s.c;
      m5_f2      <= m4_s.f2;
    end
  end

  // r1 = f2 / h, r2 = r1 / h, fr = r2 / cbrt(h)
  logic        r1_v;
  logic [30:0] r1_q;
  s2_t         r1_s;
  logic        r2_v;
  logic [30:0] r2_q;
  s2_t         r2_s;
  logic        fr_v;
  logic [30:0] fr_q;
  s2_t         fr_s;

  lif_div #(.DW(47), .VW(31), .QW(31), .SW($bits(s2_t))) u_div_r1 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(m5_v),
    .dividend({m5_f2, 16'b0}), .divisor(m5_s.h), .side_in(m5_s),
    .out_valid(r1_v), .quotient(r1_q), .side_out(r1_s)
  );

  lif_div #(.DW(47), .VW(31), .QW(31), .SW($bits(s2_t))) u_div_r2 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(r1_v),
    .dividend({r1_q, 16'b0}), .divisor(r1_s.h), .side_in(r1_s),
    .out_valid(r2_v), .quotient(r2_q), .side_out(r2_s)
  );

  lif_div #(.DW(47), .VW(21), .QW(31), .SW($bits(s2_t))) u_div_fr (
    .clk(clk), .rst(rst), .en(adv), .in_valid(r2_v),
    .dividend({r2_q, 16'b0}), .divisor(r2_s.c), .side_in(r2_s),
    .out_valid(fr_v), .quotient(fr_q), .side_out(fr_s)
  );

  // Denominator and numerator magnitude
  logic        m6_v;
  s4_t         m6_s;
  logic [31:0] m6_denom;
  logic [31:0] m6_nmag;
  logic signed [33:0] numer_neg;

  assign numer_neg = -fr_s.numer;

  always_ff @(posedge clk) begin
    if (rst) begin
      m6_v <= 1'b0;
    end else if (adv) begin
      m6_v <= fr_v;
    end
    if (adv) begin
      m6_s.pass  <= fr_s.pass;
      m6_s.dry   <= fr_s.dry;
      m6_s.q_old <= fr_s.q_old;
      m6_s.neg   <= fr_s.numer[33];
      m6_denom   <= ONE_Q16 + 32'(fr_q);
      m6_nmag    <= fr_s.numer[33] ? numer_neg[31:0] : fr_s.numer[31:0];
    end
  end

  // Final quotient
  logic        qd_v;
  logic [31:0] qd_q;
  s4_t         qd_s;

  lif_div #(.DW(48), .VW(32), .QW(32), .SW($bits(s4_t))) u_div_q (
    .clk(clk), .rst(rst), .en(adv), .in_valid(m6_v),
    .dividend({m6_nmag, 16'b0}), .divisor(m6_denom), .side_in(m6_s),
    .out_valid(qd_v), .quotient(qd_q), .side_out(qd_s)
  );

  // Saturate, select and hold the result
  logic [31:0] q_sat;

  always_comb begin
    if (qd_s.neg) begin
      q_sat = (qd_q > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - qd_q;
    end else begin
      q_sat = (qd_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= qd_v;
    end
    if (adv) begin
      if (qd_s.pass) begin
        q_new <= qd_s.q_old;
      end else if (qd_s.dry) begin
        q_new <= '0;
      end else begin
        q_new <= q_sat;
      end
      went_dry       <= !qd_s.pass && qd_s.dry;
      passed_through <= qd_s.pass;
    end
  end

endmodule

// File: rtl/local_inertial_face_flux.sv
// Local inertial face flux update, one face per transaction.
// Input channel in_valid/in_ready carries a face: kind, old discharge,
// friction discharge, and depth and bed on both sides. Output channel
// out_valid/out_ready carries q_new with the went_dry and passed_through
// flags, in input order, one result per face.
// Throughput: one face per cycle unless the receiver stalls. A face passes
// through 2 front stages, the queue, and a back end of a 22-step cube root
// and five restoring dividers, each one quotient bit per stage.
// The front end classifies faces (flow depth, dry, inactive) and feeds a
// small queue; the back end runs all faces through the same pipeline.
// When the receiver stalls, the whole back end holds, the queue fills and
// then in_ready drops. Reset empties every stage and restores the default
// coefficients. Coefficients are written through cfg_write/cfg_index/
// cfg_data and must only change while no face is in flight.
module local_inertial_face_flux #(
  parameter int QUEUE_DEPTH = lif_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lif_pkg::INDEX_W-1:0] cfg_index,
  input  logic [lif_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  face_kind,
  input  logic [31:0]                 q_old,
  input  logic [30:0]                 friction_discharge,
  input  logic [30:0]                 depth_left,
  input  logic [31:0]                 bed_left,
  input  logic [30:0]                 depth_right,
  input  logic [31:0]                 bed_right,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 q_new,
  output logic                        went_dry,
  output logic                        passed_through
);
  import lif_pkg::*;

  cfg_t  cfg;
  logic  fr_valid;
  logic  fr_ready;
  face_t fr_face;
  logic  bk_valid;
  logic  bk_ready;
  face_t bk_face;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity         <= 31'd642908;
      cfg.time_step       <= 31'd65536;
      cfg.cell_size       <= 31'd655360;
      cfg.manning_n       <= 16'd1966;
      cfg.depth_threshold <= 31'd66;
      cfg.max_flow_depth  <= 31'd655360;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_GRAVITY:   cfg.gravity         <= cfg_data;
        REG_TIME_STEP: cfg.time_step       <= cfg_data;
        REG_CELL_SIZE: cfg.cell_size       <= cfg_data;
        REG_MANNING_N: cfg.manning_n       <= cfg_data[ROUGH_W-1:0];
        REG_DEPTH_THR: cfg.depth_threshold <= cfg_data;
        REG_MAX_DEPTH: cfg.max_flow_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  lif_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .face_kind(face_kind), .q_old(q_old), .friction_discharge(friction_discharge),
    .depth_left(depth_left), .bed_left(bed_left),
    .depth_right(depth_right), .bed_right(bed_right),
    .face_valid(fr_valid), .face_ready(fr_ready), .face(fr_face)
  );

  lif_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(fr_valid), .push_ready(fr_ready), .push_data(fr_face),
    .pop_valid(bk_valid), .pop_ready(bk_ready), .pop_data(bk_face)
  );

  lif_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .face_valid(bk_valid), .face_ready(bk_ready), .face(bk_face),
    .out_valid(out_valid), .out_ready(out_ready),
    .q_new(q_new), .went_dry(went_dry), .passed_through(passed_through)
  );

`ifndef SYNTH
  a_dry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && went_dry |-> q_new == 32'd0)
    else $error("dry face with nonzero discharge");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(went_dry && passed_through))
    else $error("dry and pass-through flags both set");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule
